[hdl/hct_pkg.sv]
// ----------------------------------------------------------------------------
// hct_pkg: shared types and constants of the sensor reply checker
// Beat types of both channels, the frame-to-output status struct and the
// CRC-16/Modbus constants and the field byte positions.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [2:0]  CRC_SPAN  = 3'd6;
   localparam logic [2:0]  POS_HUM_H = 3'd2;
   localparam logic [2:0]  POS_HUM_L = 3'd3;
   localparam logic [2:0]  POS_TMP_H = 3'd4;
   localparam logic [2:0]  POS_TMP_L = 3'd5;
   localparam logic [2:0]  POS_CRC_L = 3'd6;
   localparam logic [2:0]  POS_CRC_H = 3'd7;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
      logic               frame_status;
   } rsp_type;

   // status from the frame tracker to the output stage
   typedef struct packed {
      logic    done;
      rsp_type rsp;
   } frame_out_type;

endpackage

[hdl/humidity_temp_reply_checker_top.sv]
// ----------------------------------------------------------------------------
// humidity_temp_reply_checker_top: sensor reply frame checker
// Takes an 8-byte reply frame a byte per beat, checks its CRC-16/Modbus and
// emits humidity, temperature and CRC status after the last byte.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+-------------------------------
//  req     | req_valid req_stall req_payload | one reply byte, frame start
//  rsp     | rsp_valid rsp_stall rsp_payload | one result per 8-byte frame
//
//  One byte per cycle; the CRC byte update is a combinational XOR network.
//  The result appears in the output register the cycle after the last byte.
//  Synchronous reset clears byte position, CRC and the output valid.
//  A stalled result only holds back a byte that would finish the next frame;
//  other bytes keep flowing.
// ----------------------------------------------------------------------------
module humidity_temp_reply_checker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hct_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hct_pkg::rsp_type  rsp_payload
);
   import hct_pkg::*;

   frame_out_type frame_out;
   logic          take;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   assign req_stall = rsp_valid_ff && rsp_stall && frame_out.done;
   assign take      = req_valid && !req_stall;

   hct_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .beat      (req_payload),
      .frame_out (frame_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // load a new result; drop the old one only once it has left
      if (take && frame_out.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = frame_out.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/hct_crc_byte.sv]
// ----------------------------------------------------------------------------
// hct_crc_byte: one-byte CRC-16/Modbus update
// Unrolled eight-step shift/XOR network, reflected polynomial.
// ----------------------------------------------------------------------------
module hct_crc_byte (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);
   import hct_pkg::*;

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

[hdl/hct_frame.sv]
// ----------------------------------------------------------------------------
// hct_frame: frame position tracker and field capture
// Holds byte position, running CRC and captured fields; builds the result
// on the last byte of a frame.
// ----------------------------------------------------------------------------
module hct_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  hct_pkg::req_type        beat,
   output hct_pkg::frame_out_type  frame_out
);
   import hct_pkg::*;

   logic [2:0]  pos_ff, pos_in, pos_eff;
   logic [15:0] crc_ff, crc_in, crc_base, crc_step;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] tmp_ff, tmp_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] mag;
   logic [15:0] rx_crc;

   // frame start restarts position and CRC before this byte is taken
   assign pos_eff  = beat.frame_start ? 3'd0 : pos_ff;
   assign crc_base = beat.frame_start ? CRC_INIT : crc_ff;

   hct_crc_byte u_crc (
      .crc_cur   (crc_base),
      .data_byte (beat.reply_byte),
      .crc_next  (crc_step)
   );

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      hum_in    = hum_ff;
      tmp_in    = tmp_ff;
      crc_lo_in = crc_lo_ff;
      if (take) begin
         pos_in = pos_eff + 3'd1;
         if (pos_eff < CRC_SPAN) begin
            crc_in = crc_step;
         end else if (pos_eff == POS_CRC_H) begin
            crc_in = CRC_INIT;
         end else begin
            crc_in = crc_base;
         end
         case (pos_eff)
            POS_HUM_H: hum_in[15:8] = beat.reply_byte;
            POS_HUM_L: hum_in[7:0]  = beat.reply_byte;
            POS_TMP_H: tmp_in[15:8] = beat.reply_byte;
            POS_TMP_L: tmp_in[7:0]  = beat.reply_byte;
            POS_CRC_L: crc_lo_in    = beat.reply_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      hum_ff    <= hum_in;
      tmp_ff    <= tmp_in;
      crc_lo_ff <= crc_lo_in;
   end

   // sign-magnitude to two's complement; negative zero folds to zero
   assign mag    = {1'b0, tmp_ff[14:0]};
   assign rx_crc = {beat.reply_byte, crc_lo_ff};

   always_comb begin
      frame_out.done                   = (pos_eff == POS_CRC_H);
      frame_out.rsp.humidity_tenths    = hum_ff;
      frame_out.rsp.temperature_tenths = tmp_ff[15] ? -mag : mag;
      frame_out.rsp.frame_status       = (crc_base != rx_crc);
   end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: sensor reply checker
// Sends 8-byte reply frames a beat at a time with random gaps on both sides
// and checks every result against a local CRC-16/Modbus frame tracker.
// Stimulus mixes directed frames with random good, bad, cut-short and noisy
// byte streams.
// ----------------------------------------------------------------------------
module testbench;
   import hct_pkg::*;

   localparam int          RANDOM_BEATS  = 550;
   localparam int          IDLE_LIMIT    = 2000;
   localparam int          SETTLE_CYCLES = 16;
   localparam logic [15:0] TEMP_NEG_ZERO = 16'h8000;

   typedef struct packed {
      req_type beat;
      logic    drain_first;
   } queued_byte_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   queued_byte_type byte_backlog[$];
   rsp_type         expected_readings[$];
   int              queued_beats = 0;
   int              fail_count = 0;

   // frame tracker state
   logic [2:0]  pos_q = '0;
   logic [15:0] crc_run = CRC_INIT;
   logic [15:0] hum_capture = '0;
   logic [15:0] temp_capture = '0;
   logic [7:0]  crc_low_capture = '0;

   // driver and monitor bookkeeping
   logic        results_owed = 1'b0;
   bit          took, got, send_calm, take_calm;
   int          send_wait = 0;
   int          take_wait = 0;
   int          quiet_cycles = 0;
   rsp_type     want, seen;

   humidity_temp_reply_checker_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void track_reply_byte(input req_type beat);
      logic [2:0]  pos;
      logic [15:0] rx_crc;
      logic [14:0] mag;
      rsp_type     r;
      if (beat.frame_start) begin
         pos_q   = '0;
         crc_run = CRC_INIT;
      end
      pos = pos_q;
      if (pos < CRC_SPAN) begin
         crc_run = crc16_update(crc_run, beat.reply_byte);
      end
      case (pos)
         POS_HUM_H: hum_capture[15:8]  = beat.reply_byte;
         POS_HUM_L: hum_capture[7:0]   = beat.reply_byte;
         POS_TMP_H: temp_capture[15:8] = beat.reply_byte;
         POS_TMP_L: temp_capture[7:0]  = beat.reply_byte;
         POS_CRC_L: crc_low_capture    = beat.reply_byte;
         POS_CRC_H: begin
            rx_crc = {beat.reply_byte, crc_low_capture};
            mag    = temp_capture[14:0];
            r.humidity_tenths    = hum_capture;
            // sign-magnitude to two's complement; negative zero folds to 0
            r.temperature_tenths = temp_capture[15] ? 16'h0000 - {1'b0, mag} : {1'b0, mag};
            r.frame_status       = (crc_run != rx_crc);
            expected_readings.push_back(r);
            crc_run = CRC_INIT;
         end
         default: ;
      endcase
      pos_q = pos + 3'd1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic queue_beat(input logic [7:0] b, input bit start, input bit drain);
      queued_byte_type q;
      q.beat.reply_byte  = b;
      q.beat.frame_start = start;
      q.drain_first      = drain;
      byte_backlog.push_back(q);
      queued_beats++;
   endtask

   task automatic queue_frame(input logic [15:0] hum, input logic [15:0] temp,
                              input bit crc_good, input bit with_start, input bit drain);
      logic [7:0]  body[6];
      logic [15:0] crc;
      body[0] = 8'($urandom);
      body[1] = 8'($urandom);
      body[2] = hum[15:8];
      body[3] = hum[7:0];
      body[4] = temp[15:8];
      body[5] = temp[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         crc = crc16_update(crc, body[i]);
      end
      if (!crc_good) begin
         crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      for (int i = 0; i < 6; i++) begin
         queue_beat(body[i], (i == 0) && with_start, (i == 0) && drain);
      end
      // CRC goes out low byte first
      queue_beat(crc[7:0], 1'b0, 1'b0);
      queue_beat(crc[15:8], 1'b0, 1'b0);
   endtask

   // driver: present the next backlog byte after its drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 17);
         end
         if (took || !req_valid) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() > 0 &&
                         !(byte_backlog[0].drain_first && (results_owed || took))) begin
               req_payload <= byte_backlog[0].beat;
               req_valid   <= 1'b1;
               void'(byte_backlog.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check results first, then track accepted bytes
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         results_owed <= 1'b0;
         quiet_cycles = 0;
      end else begin
         got = rsp_valid && !rsp_stall;
         if (got) begin
            seen = rsp_payload;
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", seen));
            end else begin
               want = expected_readings.pop_front();
               if (seen.humidity_tenths !== want.humidity_tenths)
                  report_mismatch($sformatf("humidity got %h want %h",
                                            seen.humidity_tenths, want.humidity_tenths));
               if (seen.temperature_tenths !== want.temperature_tenths)
                  report_mismatch($sformatf("temperature got %0d want %0d",
                                            seen.temperature_tenths, want.temperature_tenths));
               if (seen.frame_status !== want.frame_status)
                  report_mismatch($sformatf("status got %b want %b",
                                            seen.frame_status, want.frame_status));
            end
            if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
            take_wait = take_calm ? 0 : $urandom_range(0, 17);
         end else if (rsp_valid && take_wait > 0) begin
            take_wait--;
         end
         rsp_stall <= (take_wait > 0);

         if (req_valid && !req_stall) track_reply_byte(req_payload);
         results_owed <= (expected_readings.size() != 0);

         if (got || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int         directed_beats;
      int         kind;
      int         span;
      bit         need_start;
      logic [15:0] temp;

      // max humidity, negative zero, good CRC
      queue_frame(16'hFFFF, TEMP_NEG_ZERO, 1'b1, 1'b1, 1'b0);
      // back-to-back with no frame start, most negative temperature, bad CRC
      queue_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
      // cut a frame short, then restart mid-frame
      queue_beat(8'h03, 1'b1, 1'b0);
      queue_beat(8'h04, 1'b0, 1'b0);
      queue_frame(16'h1234, 16'h7FFF, 1'b1, 1'b1, 1'b0);

      directed_beats = queued_beats;
      need_start = 1'b0;
      // first random frame waits until every directed result is in
      queue_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b1);
      while (queued_beats - directed_beats < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         temp = ($urandom_range(0, 7) == 0) ? TEMP_NEG_ZERO : 16'($urandom);
         if (kind < 75) begin
            queue_frame(16'($urandom), temp, kind >= 12,
                        need_start || ($urandom_range(0, 2) == 0),
                        $urandom_range(0, 19) == 0);
            need_start = 1'b0;
         end else if (kind < 88) begin
            // drop a partial frame; realign on the next one
            span = $urandom_range(1, 7);
            for (int i = 0; i < span; i++) queue_beat(8'($urandom), i == 0, 1'b0);
            need_start = 1'b1;
         end else begin
            span = $urandom_range(1, 12);
            for (int i = 0; i < span; i++)
               queue_beat(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
            need_start = 1'b1;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
hdl/hct_pkg.sv
hdl/hct_crc_byte.sv
hdl/hct_frame.sv
hdl/humidity_temp_reply_checker_top.sv
dv/testbench.sv
